>>> design/mlbad_pkg.sv
// Shared types, constants and helper functions of the multilook box-average decimator.
// Used by every module of the block and by its checker; depends on nothing else.
`default_nettype none

package mlbad_pkg;

    // Field and port widths.
    localparam int SAMPLE_W   = 32;
    localparam int COL_W      = 10;
    localparam int WIN_W      = 16;
    localparam int DIVR_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int PAD_W      = M_TDATA_W - COL_W - SAMPLE_W;

    // Default sizes of the line buffer and of the look factors.
    localparam int DEF_MAX_OUT_COLS = 1024;
    localparam int DEF_MAX_LOOK     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NLOOK_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NLOOK_COL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMP_ROW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMP_COL = 3'd6;

    // Largest look or subsampling factor that a 5-bit register can reach.
    function automatic int look_cap(input int max_look);
        return (max_look < 31) ? max_look : 31;
    endfunction

    // Largest window period and largest window size.
    function automatic int period_max(input int max_look);
        return look_cap(max_look) * look_cap(max_look);
    endfunction

    // Width of the row phase and of the position within a window period.
    function automatic int phase_w(input int max_look);
        int pm;
        pm = period_max(max_look);
        return (pm > 1) ? $clog2(pm) : 1;
    endfunction

    // Width of a window sum: one sample plus the growth of the largest window.
    function automatic int acc_w(input int max_look);
        int pm;
        pm = period_max(max_look);
        return SAMPLE_W + ((pm > 1) ? $clog2(pm) : 0);
    endfunction

    // Address width of the line buffer.
    function automatic int addr_w(input int max_out_cols);
        return (max_out_cols > 1) ? $clog2(max_out_cols) : 1;
    endfunction

    // Result buffer depth: covers the full divider latency.
    function automatic int obuf_depth(input int max_look);
        return 2 ** $clog2(acc_w(max_look) + 8);
    endfunction

    // A zero factor acts as one, a factor above the cap acts as the cap.
    function automatic logic [4:0] look_clamp(input logic [4:0] v, input int cap);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (int'(v) > cap) begin
            r = 5'(cap);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // One accepted item as seen by the line buffer.
    typedef struct packed {
        logic                       valid;
        logic                       init;
        logic                       close;
        logic                       last;
        logic [WIN_W-1:0]           win;
        logic [COL_W-1:0]           column;
        logic [DIVR_W-1:0]          divisor;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    // Tag that travels with a closed window through the divider.
    typedef struct packed {
        logic              last;
        logic [COL_W-1:0]  column;
        logic [DIVR_W-1:0] divisor;
    } meta_t;

    // One finished output item.
    typedef struct packed {
        logic                last;
        logic [COL_W-1:0]    column;
        logic [SAMPLE_W-1:0] average;
    } res_t;

endpackage

`default_nettype wire

>>> design/multilook_box_average_decimator_core.sv
// Multilook box-average decimator: top level.
// Depends on mlbad_pkg, mlbad_ctrl, mlbad_acc, mlbad_div and mlbad_obuf.
//
// Usage:
// - s_ channel: one signed Q16.16 sample per item, in raster order of one matrix plane.
// - m_ channel: one item per closed window, the window mean truncated toward zero,
//   with its output column; m_tlast marks the last output column of a row.
// - cfg_ channel: register writes (index 0..6: row_width, col_offset, out_cols,
//   nlook_row, nlook_col, subsamp_row, subsamp_col); cfg_ready is always high.
// Throughput: one sample per cycle while s_tready is high. After each register write
//   s_tready stays low while a 16-step shift-subtract unit recomputes the window position
//   of the current column.
// Result path: from the edge that accepts the sample closing its window, a result passes
//   the line-buffer read, update, divider entry, 40 quotient-bit stages, divider exit,
//   queue write and output register before it appears on m_tvalid.
// Partial sums live in a line buffer of MAX_OUT_COLS entries, one read and one
//   write per cycle, with forwarding between back-to-back updates of the same entry.
// Stall: results queue in a 64-entry memory; a window-closing sample is only taken
//   while a queue slot is free, so a stalled receiver eventually holds off s_tready
//   while samples that close nothing still flow.
// Reset (aresetn low, synchronous): registers take their defaults, counters clear,
//   queue and pipeline empty. The line buffer is not cleared; every window starts
//   by overwriting its entry.
`default_nettype none

module multilook_box_average_decimator_core
    import mlbad_pkg::*;
#(
    parameter int MAX_OUT_COLS = DEF_MAX_OUT_COLS,
    parameter int MAX_LOOK     = DEF_MAX_LOOK
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // Input samples.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [31:0] sample_value
    // Output averages.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [31:0] average_value, [41:32] out_column
    output logic                        m_tlast    // row_done
);

    localparam int ACC_W = acc_w(MAX_LOOK);

    cmd_t                    cmd;
    logic                    room;
    logic                    sum_valid;
    logic signed [ACC_W-1:0] sum;
    meta_t                   meta;
    logic                    res_valid;
    res_t                    res;

    mlbad_ctrl #(
        .MAX_OUT_COLS (MAX_OUT_COLS),
        .MAX_LOOK     (MAX_LOOK)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_sample  (s_tdata[SAMPLE_W-1:0]),
        .room      (room),
        .cmd       (cmd)
    );

    mlbad_acc #(
        .MAX_OUT_COLS (MAX_OUT_COLS),
        .MAX_LOOK     (MAX_LOOK)
    ) u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sum_valid (sum_valid),
        .sum       (sum),
        .meta      (meta)
    );

    mlbad_div #(
        .MAX_LOOK (MAX_LOOK)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_sum    (sum),
        .in_meta   (meta),
        .res_valid (res_valid),
        .res       (res)
    );

    mlbad_obuf #(
        .MAX_LOOK (MAX_LOOK)
    ) u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .reserve  (cmd.valid && cmd.close),
        .room     (room),
        .wr_valid (res_valid),
        .wr_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> design/mlbad_ctrl.sv
// Configuration registers, raster counters and window tracking of the decimator.
// Depends on mlbad_pkg; feeds mlbad_acc with one command per accepted item inside a window.
`default_nettype none

module mlbad_ctrl
    import mlbad_pkg::*;
#(
    parameter int MAX_OUT_COLS = DEF_MAX_OUT_COLS,
    parameter int MAX_LOOK     = DEF_MAX_LOOK
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       room,
    output cmd_t                            cmd
);

    localparam int PH_W      = phase_w(MAX_LOOK);
    localparam int STEP_W    = $clog2(WIN_W + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [15:0] row_width_reg, col_offset_reg;
    logic [10:0] out_cols_reg;
    logic [4:0]  nlook_row_reg, nlook_col_reg, subsamp_row_reg, subsamp_col_reg;

    logic [15:0]      col_reg, col_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [PH_W-1:0]  within_reg, within_next;
    logic [WIN_W-1:0] win_reg, win_next;

    logic [1:0]        st_reg, st_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [WIN_W-1:0]  dvd_reg, dvd_next;

    logic [4:0]        nlr, nlc, ssr, ssc;
    logic [DIVR_W-1:0] rperiod, cperiod, wsize;
    logic [WIN_W-1:0]  ncols;
    logic              in_off, active, init, close, last, closing, accept, row_end, cfg_wr;
    logic [DIVR_W:0]   div_try;
    logic              div_ge;

    // Effective factors after clamping, and the derived periods.
    always_comb begin
        nlr     = look_clamp(nlook_row_reg, MAX_LOOK);
        nlc     = look_clamp(nlook_col_reg, MAX_LOOK);
        ssr     = look_clamp(subsamp_row_reg, MAX_LOOK);
        ssc     = look_clamp(subsamp_col_reg, MAX_LOOK);
        rperiod = DIVR_W'(ssr) * DIVR_W'(nlr);
        cperiod = DIVR_W'(ssc) * DIVR_W'(nlc);
        wsize   = DIVR_W'(nlr) * DIVR_W'(nlc);
        ncols   = ({5'd0, out_cols_reg} > WIN_W'(MAX_OUT_COLS)) ?
                  WIN_W'(MAX_OUT_COLS) : {5'd0, out_cols_reg};
    end

    // Classify the current raster position.
    always_comb begin
        in_off  = col_reg >= col_offset_reg;
        active  = in_off && (DIVR_W'(phase_reg) < DIVR_W'(nlr))
                  && (DIVR_W'(within_reg) < DIVR_W'(nlc)) && (win_reg < ncols);
        init    = (phase_reg == '0) && (within_reg == '0);
        close   = (DIVR_W'(phase_reg) == DIVR_W'(nlr) - DIVR_W'(1))
                  && (DIVR_W'(within_reg) == DIVR_W'(nlc) - DIVR_W'(1));
        last    = (17'(win_reg) + 17'd1) == 17'(ncols);
        closing = active && close;
    end

    // A closing item needs a reserved slot in the result buffer.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign s_tready  = (st_reg == ST_IDLE) && (!closing || room);
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        cmd.valid   = accept && active;
        cmd.init    = init;
        cmd.close   = close;
        cmd.last    = last;
        cmd.win     = win_reg;
        cmd.column  = win_reg[COL_W-1:0];
        cmd.divisor = wsize;
        cmd.sample  = s_sample;
    end

    // One restoring division step for the window position after a register write.
    always_comb begin
        div_try = {rem_reg, dvd_reg[WIN_W-1]};
        div_ge  = div_try >= {1'b0, cperiod};
    end

    // Next state of the counters and of the position sequencer.
    always_comb begin
        col_next    = col_reg;
        phase_next  = phase_reg;
        within_next = within_reg;
        win_next    = win_reg;
        st_next     = st_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        row_end     = col_reg == (row_width_reg - 16'd1);

        if (accept) begin
            if (row_end) begin
                col_next = 16'd0;
                if ((DIVR_W + 1)'(phase_reg) + (DIVR_W + 1)'(1) >= (DIVR_W + 1)'(rperiod)) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_reg + PH_W'(1);
                end
            end else begin
                col_next = col_reg + 16'd1;
            end
            if (col_next == col_offset_reg) begin
                within_next = '0;
                win_next    = '0;
            end else if (col_next > col_offset_reg) begin
                if ((DIVR_W + 1)'(within_reg) + (DIVR_W + 1)'(1) == (DIVR_W + 1)'(cperiod)) begin
                    within_next = '0;
                    win_next    = win_reg + WIN_W'(1);
                end else begin
                    within_next = within_reg + PH_W'(1);
                end
            end
        end

        case (st_reg)
            ST_IDLE: begin
            end
            ST_LOAD: begin
                rem_next  = '0;
                dvd_next  = col_reg - col_offset_reg;
                step_next = STEP_W'(WIN_W);
                st_next   = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = div_ge ? DIVR_W'(div_try - {1'b0, cperiod}) : DIVR_W'(div_try);
                dvd_next  = {dvd_reg[WIN_W-2:0], div_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    within_next = PH_W'(rem_next);
                    win_next    = dvd_next;
                    st_next     = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // A register write restarts the position computation.
        if (cfg_wr) begin
            st_next = ST_LOAD;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            phase_reg  <= '0;
            within_reg <= '0;
            win_reg    <= '0;
            st_reg     <= ST_IDLE;
        end else begin
            col_reg    <= col_next;
            phase_reg  <= phase_next;
            within_reg <= within_next;
            win_reg    <= win_next;
            st_reg     <= st_next;
        end
    end

    // Sequencer datapath.
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
    end

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg   <= 16'd1;
            col_offset_reg  <= 16'd0;
            out_cols_reg    <= 11'd1;
            nlook_row_reg   <= 5'd1;
            nlook_col_reg   <= 5'd1;
            subsamp_row_reg <= 5'd1;
            subsamp_col_reg <= 5'd1;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_ROW_WIDTH:   row_width_reg   <= cfg_data;
                CFG_COL_OFFSET:  col_offset_reg  <= cfg_data;
                CFG_OUT_COLS:    out_cols_reg    <= cfg_data[10:0];
                CFG_NLOOK_ROW:   nlook_row_reg   <= cfg_data[4:0];
                CFG_NLOOK_COL:   nlook_col_reg   <= cfg_data[4:0];
                CFG_SUBSAMP_ROW: subsamp_row_reg <= cfg_data[4:0];
                CFG_SUBSAMP_COL: subsamp_col_reg <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/mlbad_acc.sv
// Line buffer of partial window sums with read-modify-write and write forwarding.
// Depends on mlbad_pkg; takes commands from mlbad_ctrl and feeds mlbad_div.
`default_nettype none

module mlbad_acc
    import mlbad_pkg::*;
#(
    parameter int MAX_OUT_COLS = DEF_MAX_OUT_COLS,
    parameter int MAX_LOOK     = DEF_MAX_LOOK
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire cmd_t                            cmd,
    output logic                                 sum_valid,
    output logic signed [acc_w(MAX_LOOK)-1:0]    sum,
    output meta_t                                meta
);

    localparam int ACC_W = acc_w(MAX_LOOK);
    localparam int AW    = addr_w(MAX_OUT_COLS);

    logic signed [ACC_W-1:0] mem [MAX_OUT_COLS];
    logic signed [ACC_W-1:0] rd_data_reg;

    logic                       s1_valid_reg, s1_init_reg, s1_close_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    meta_t                      s1_meta_reg;

    logic                    fw_valid_reg;
    logic [AW-1:0]           fw_addr_reg;
    logic signed [ACC_W-1:0] fw_sum_reg;

    logic                    sum_valid_reg;
    logic signed [ACC_W-1:0] sum_reg;
    meta_t                   meta_reg;

    logic signed [ACC_W-1:0] base, sext, new_sum;

    // Read port: issued in the cycle the item is accepted.
    always_ff @(posedge aclk) begin
        if (cmd.valid) begin
            rd_data_reg <= mem[cmd.win[AW-1:0]];
        end
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= new_sum;
        end
    end

    // Update: take the value written in the previous cycle when the same entry is hit.
    always_comb begin
        base    = (fw_valid_reg && (fw_addr_reg == s1_addr_reg)) ? fw_sum_reg : rd_data_reg;
        sext    = ACC_W'(s1_sample_reg);
        new_sum = s1_init_reg ? sext : base + sext;
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= cmd.valid;
            fw_valid_reg  <= s1_valid_reg;
            sum_valid_reg <= s1_valid_reg && s1_close_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        s1_init_reg         <= cmd.init;
        s1_close_reg        <= cmd.close;
        s1_addr_reg         <= cmd.win[AW-1:0];
        s1_sample_reg       <= cmd.sample;
        s1_meta_reg.last    <= cmd.last;
        s1_meta_reg.column  <= cmd.column;
        s1_meta_reg.divisor <= cmd.divisor;
        fw_addr_reg         <= s1_addr_reg;
        fw_sum_reg          <= new_sum;
        sum_reg             <= new_sum;
        meta_reg            <= s1_meta_reg;
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;
    assign meta      = meta_reg;

endmodule

`default_nettype wire

>>> design/mlbad_div.sv
// Pipelined signed divider: window sum over window size, truncated toward zero.
// Depends on mlbad_pkg; one quotient bit per stage, one item may enter each cycle.
`default_nettype none

module mlbad_div
    import mlbad_pkg::*;
#(
    parameter int MAX_LOOK = DEF_MAX_LOOK
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    input  wire logic signed [acc_w(MAX_LOOK)-1:0]   in_sum,
    input  wire meta_t                               in_meta,
    output logic                                     res_valid,
    output res_t                                     res
);

    localparam int ACC_W = acc_w(MAX_LOOK);
    localparam int N     = ACC_W;

    logic              v_reg   [0:N];
    logic              neg_reg [0:N];
    logic [DIVR_W-1:0] rem_reg [0:N];
    logic [ACC_W-1:0]  dvd_reg [0:N];
    meta_t             tag_reg [0:N];

    logic [ACC_W-1:0]    sum_u, mag;
    logic [SAMPLE_W-1:0] quo;
    logic                res_valid_reg;
    res_t                res_reg;

    // Entry stage: magnitude and sign of the sum.
    always_comb begin
        sum_u = in_sum;
        mag   = in_sum[ACC_W-1] ? (~sum_u + ACC_W'(1)) : sum_u;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg[0] <= in_sum[ACC_W-1];
        rem_reg[0] <= '0;
        dvd_reg[0] <= mag;
        tag_reg[0] <= in_meta;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic [DIVR_W:0] trial;
        logic            ge;

        always_comb begin
            trial = {rem_reg[k-1], dvd_reg[k-1][ACC_W-1]};
            ge    = trial >= {1'b0, tag_reg[k-1].divisor};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            neg_reg[k] <= neg_reg[k-1];
            rem_reg[k] <= ge ? DIVR_W'(trial - {1'b0, tag_reg[k-1].divisor})
                             : DIVR_W'(trial);
            dvd_reg[k] <= {dvd_reg[k-1][ACC_W-2:0], ge};
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    // Exit stage: restore the sign.
    assign quo = dvd_reg[N][SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= v_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        res_reg.average <= neg_reg[N] ? (~quo + SAMPLE_W'(1)) : quo;
        res_reg.column  <= tag_reg[N].column;
        res_reg.last    <= tag_reg[N].last;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> design/mlbad_obuf.sv
// Result buffer: a memory queue with a registered read into the output item register.
// Depends on mlbad_pkg; keeps the slot reservation count that throttles closing items.
`default_nettype none

module mlbad_obuf
    import mlbad_pkg::*;
#(
    parameter int MAX_LOOK = DEF_MAX_LOOK
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 reserve,
    output logic                      room,
    input  wire logic                 wr_valid,
    input  wire res_t                 wr_res,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    localparam int DEPTH = obuf_depth(MAX_LOOK);
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    res_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] credit_reg, credit_next;
    logic          out_valid_reg;
    res_t          out_res_reg;
    logic          load, taken;

    assign taken = out_valid_reg && m_tready;
    assign load  = (fill_reg != '0) && (!out_valid_reg || m_tready);
    assign room  = credit_reg < CW'(DEPTH);

    // Slots held from acceptance of a closing item until its result is taken.
    always_comb begin
        credit_next = credit_reg;
        if (reserve && !taken) begin
            credit_next = credit_reg + CW'(1);
        end else if (!reserve && taken) begin
            credit_next = credit_reg - CW'(1);
        end
        fill_next = fill_reg;
        if (wr_valid && !load) begin
            fill_next = fill_reg + CW'(1);
        end else if (!wr_valid && load) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    // Queue storage with a registered read.
    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            mem[wr_ptr_reg] <= wr_res;
        end
        if (load) begin
            out_res_reg <= mem[rd_ptr_reg];
        end
    end

    // Pointers, counts and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            credit_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (load) begin
                rd_ptr_reg    <= rd_ptr_reg + PW'(1);
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_res_reg.column, out_res_reg.average};
    assign m_tlast  = out_res_reg.last;

endmodule

`default_nettype wire

>>> design/mlbad_chk.sv
// Port-level checker for the multilook box-average decimator, bound to the top level.
// Depends on mlbad_pkg and observes the top-level ports only.
`default_nettype none

module mlbad_chk
    import mlbad_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    // A stalled output item stays and keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Reset empties the result path.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A register write holds off input items while the window position is rebuilt.
    a_cfg_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready ##1 !s_tready)
        else $error("input taken during window position recompute");

    // The pad bits above the output column stay zero on every item.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:COL_W+SAMPLE_W] == '0)
        else $error("nonzero pad bits in output item");

endmodule

bind multilook_box_average_decimator_core mlbad_chk u_mlbad_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

`default_nettype wire
